// File: design/rds_pkg.sv
// Shared types and constants for the retune delta smoother.
`default_nettype none
package rds_pkg;

	// Register widths
	localparam int PITCH_W = 15;
	localparam int COEF_W  = 16;
	localparam int DATA_W  = 16;
	localparam int IDX_W   = 3;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN   = 3'd2;
	localparam logic [IDX_W-1:0] REG_VIB    = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

	// Register reset values
	localparam logic [PITCH_W-1:0] TARGET_RST = 15'd15360;
	localparam logic [COEF_W-1:0]  ALPHA_RST  = 16'd60000;
	localparam logic [COEF_W-1:0]  GAIN_RST   = 16'd32768;
	localparam logic [PITCH_W-1:0] VIB_RST    = 15'd0;
	localparam logic [PITCH_W-1:0] LIMIT_RST  = 15'd3072;

	// Digit-serial multiplier: 4-bit digits of a 16-bit coefficient
	localparam int DIGIT_W = 4;
	localparam int DIGITS  = COEF_W / DIGIT_W;
	localparam int DCNT_W  = $clog2(DIGITS);
	localparam int MC_W    = 17;            // multiplicand magnitude
	localparam int ACC_W   = MC_W + COEF_W; // product magnitude
	localparam int SC_W    = 18;            // signed scaled value and difference
	localparam int SUM_W   = 36;            // signed IIR sum
	localparam int RMAG_W  = SUM_W - COEF_W;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_GAIN  = 9'b000000100,
		S_SCALE = 9'b000001000,
		S_DIFF  = 9'b000010000,
		S_ALPHA = 9'b000100000,
		S_FIN   = 9'b001000000,
		S_ROUND = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

// File: design/retune_delta_smoother_unit.sv
// Retune delta smoother: per-frame pitch correction with a digit-serial IIR.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  input    | in_valid / in_ready      | voiced, pitch_midi[14:0]
//  output   | out_valid / out_ready    | correction[15:0] (signed)
//  config   | cfg_we (no wait)         | cfg_index[2:0], cfg_data[15:0]
//
// A voiced frame runs the gain multiply and then the alpha multiply, an unvoiced
// frame only the alpha multiply; in_ready is high only in the idle step. Each
// multiply runs one 4-bit coefficient digit per cycle through one shared
// shift-and-add unit.
// Reset clears the smoothing state to zero and loads the register defaults.
// A result waits in the output register while the next frame is taken; the
// sequencer holds its last step only while that register is full and out_ready is low.
`default_nettype none
module retune_delta_smoother_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               voiced,
	input  wire  [rds_pkg::PITCH_W-1:0]       pitch_midi,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [rds_pkg::DATA_W-1:0] correction,
	input  wire                               cfg_we,
	input  wire  [rds_pkg::IDX_W-1:0]         cfg_index,
	input  wire  [rds_pkg::DATA_W-1:0]        cfg_data
);

	// Configuration registers
	logic [rds_pkg::PITCH_W-1:0] target_q;
	logic [rds_pkg::COEF_W-1:0]  alpha_q;
	logic [rds_pkg::COEF_W-1:0]  gain_q;
	logic [rds_pkg::PITCH_W-1:0] vib_q;
	logic [rds_pkg::PITCH_W-1:0] limit_q;

	// Sequencer and datapath
	rds_pkg::state_t                 state_q;
	logic                            voiced_q;
	logic signed [rds_pkg::DATA_W-1:0] raw_q;
	logic signed [rds_pkg::DATA_W-1:0] prev_q;
	logic                            neg_q;
	logic [rds_pkg::ACC_W-1:0]       mcand_q;
	logic [rds_pkg::COEF_W-1:0]      mplier_q;
	logic [rds_pkg::ACC_W-1:0]       acc_q;
	logic [rds_pkg::DCNT_W-1:0]      dig_q;
	logic signed [rds_pkg::SC_W-1:0] scaled_q;
	logic signed [rds_pkg::SUM_W-1:0] sum_q;
	logic                            res_sign_q;
	logic [rds_pkg::RMAG_W-1:0]      res_mag_q;
	logic                            out_valid_q;
	logic signed [rds_pkg::DATA_W-1:0] correction_q;

	// Combinational helpers
	logic [rds_pkg::DATA_W-1:0]      raw_mag;
	logic                            bypass;
	logic [rds_pkg::DATA_W-1:0]      prev_mag;
	logic [rds_pkg::ACC_W-1:0]       pp;
	logic                            last_digit;
	logic [rds_pkg::ACC_W-1:0]       gain_rnd;
	logic [rds_pkg::MC_W-1:0]        scaled_mag;
	logic signed [rds_pkg::SC_W-1:0] diff;
	logic [rds_pkg::SC_W-1:0]        diff_mag;
	logic [rds_pkg::SUM_W-1:0]       prod_mask;
	logic signed [rds_pkg::SUM_W-1:0] sum_next;
	logic [rds_pkg::SUM_W-1:0]       sum_mask;
	logic [rds_pkg::SUM_W-1:0]       rnd_sum;
	logic [rds_pkg::PITCH_W-1:0]     clamp_mag;
	logic signed [rds_pkg::DATA_W-1:0] result;
	logic                            out_load;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= rds_pkg::TARGET_RST;
			alpha_q  <= rds_pkg::ALPHA_RST;
			gain_q   <= rds_pkg::GAIN_RST;
			vib_q    <= rds_pkg::VIB_RST;
			limit_q  <= rds_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rds_pkg::REG_TARGET: target_q <= cfg_data[rds_pkg::PITCH_W-1:0];
				rds_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				rds_pkg::REG_GAIN:   gain_q   <= cfg_data;
				rds_pkg::REG_VIB:    vib_q    <= cfg_data[rds_pkg::PITCH_W-1:0];
				rds_pkg::REG_LIMIT:  limit_q  <= cfg_data[rds_pkg::PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Deviation magnitude and vibrato bypass
	assign raw_mag  = raw_q[rds_pkg::DATA_W-1] ? rds_pkg::DATA_W'(-raw_q) : raw_q;
	assign bypass   = raw_mag < {1'b0, vib_q};
	assign prev_mag = prev_q[rds_pkg::DATA_W-1] ? rds_pkg::DATA_W'(-prev_q) : prev_q;

	// One multiplier digit per cycle
	assign pp = mcand_q * {{(rds_pkg::ACC_W-rds_pkg::DIGIT_W){1'b0}},
		mplier_q[rds_pkg::DIGIT_W-1:0]};
	assign last_digit = dig_q == rds_pkg::DCNT_W'(rds_pkg::DIGITS - 1);

	// Gain product rounded half away from zero, Q1.15 back to Q.8
	assign gain_rnd   = acc_q + rds_pkg::ACC_W'(1 << 14);
	assign scaled_mag = gain_rnd[rds_pkg::MC_W+14:15];

	// Difference that the coefficient multiplies: prev - scaled
	assign diff     = {{(rds_pkg::SC_W-rds_pkg::DATA_W){prev_q[rds_pkg::DATA_W-1]}}, prev_q}
		- scaled_q;
	assign diff_mag = diff[rds_pkg::SC_W-1] ? rds_pkg::SC_W'(-diff) : diff;

	// a*s + (1-a)*scaled = scaled*2^16 + a*(s - scaled), sign folded as mask + carry
	assign prod_mask = {rds_pkg::SUM_W{neg_q}};
	assign sum_next  = $signed({{(rds_pkg::SUM_W-rds_pkg::SC_W-rds_pkg::COEF_W)
		{scaled_q[rds_pkg::SC_W-1]}}, scaled_q, {rds_pkg::COEF_W{1'b0}}})
		+ $signed(({{(rds_pkg::SUM_W-rds_pkg::ACC_W){1'b0}}, acc_q} ^ prod_mask))
		+ $signed({{(rds_pkg::SUM_W-1){1'b0}}, neg_q});

	// |sum| + half, one add
	assign sum_mask = {rds_pkg::SUM_W{sum_q[rds_pkg::SUM_W-1]}};
	assign rnd_sum  = (sum_q ^ sum_mask)
		+ {{(rds_pkg::SUM_W-1){1'b0}}, sum_q[rds_pkg::SUM_W-1]}
		+ rds_pkg::SUM_W'(1 << 15);

	// Clamp (voiced only) and restore sign
	assign clamp_mag = (voiced_q && res_mag_q > {{(rds_pkg::RMAG_W-rds_pkg::PITCH_W){1'b0}},
		limit_q}) ? limit_q : res_mag_q[rds_pkg::PITCH_W-1:0];
	assign result = res_sign_q ? -$signed({1'b0, clamp_mag}) : $signed({1'b0, clamp_mag});

	assign out_load = (state_q == rds_pkg::S_OUT) && (!out_valid_q || out_ready);
	assign in_ready = state_q == rds_pkg::S_IDLE;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rds_pkg::S_IDLE;
			dig_q   <= '0;
			prev_q  <= '0;
		end else begin
			case (state_q)
				rds_pkg::S_IDLE: begin
					if (in_valid) state_q <= rds_pkg::S_PREP;
				end
				rds_pkg::S_PREP: begin
					state_q <= voiced_q ? rds_pkg::S_GAIN : rds_pkg::S_ALPHA;
				end
				rds_pkg::S_GAIN: begin
					dig_q <= dig_q + 1'b1;
					if (last_digit) state_q <= rds_pkg::S_SCALE;
				end
				rds_pkg::S_SCALE: state_q <= rds_pkg::S_DIFF;
				rds_pkg::S_DIFF:  state_q <= rds_pkg::S_ALPHA;
				rds_pkg::S_ALPHA: begin
					dig_q <= dig_q + 1'b1;
					if (last_digit) state_q <= voiced_q ? rds_pkg::S_FIN : rds_pkg::S_ROUND;
				end
				rds_pkg::S_FIN:   state_q <= rds_pkg::S_ROUND;
				rds_pkg::S_ROUND: state_q <= rds_pkg::S_OUT;
				rds_pkg::S_OUT: begin
					if (out_load) begin
						prev_q  <= result;
						state_q <= rds_pkg::S_IDLE;
					end
				end
				default: state_q <= rds_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rds_pkg::S_IDLE: begin
				voiced_q <= voiced;
				raw_q    <= $signed({1'b0, target_q}) - $signed({1'b0, pitch_midi});
			end
			rds_pkg::S_PREP: begin
				acc_q <= '0;
				if (voiced_q) begin
					neg_q    <= raw_q[rds_pkg::DATA_W-1];
					mcand_q  <= bypass ? '0
						: {{(rds_pkg::ACC_W-rds_pkg::DATA_W){1'b0}}, raw_mag};
					mplier_q <= gain_q;
				end else begin
					neg_q    <= prev_q[rds_pkg::DATA_W-1];
					mcand_q  <= {{(rds_pkg::ACC_W-rds_pkg::DATA_W){1'b0}}, prev_mag};
					mplier_q <= alpha_q;
				end
			end
			rds_pkg::S_GAIN, rds_pkg::S_ALPHA: begin
				acc_q    <= acc_q + pp;
				mcand_q  <= mcand_q << rds_pkg::DIGIT_W;
				mplier_q <= mplier_q >> rds_pkg::DIGIT_W;
			end
			rds_pkg::S_SCALE: begin
				scaled_q <= neg_q ? -$signed({1'b0, scaled_mag}) : $signed({1'b0, scaled_mag});
			end
			rds_pkg::S_DIFF: begin
				acc_q    <= '0;
				neg_q    <= diff[rds_pkg::SC_W-1];
				mcand_q  <= {{(rds_pkg::ACC_W-rds_pkg::SC_W){1'b0}}, diff_mag};
				mplier_q <= alpha_q;
			end
			rds_pkg::S_FIN: sum_q <= sum_next;
			rds_pkg::S_ROUND: begin
				if (voiced_q) begin
					res_sign_q <= sum_q[rds_pkg::SUM_W-1];
					res_mag_q  <= rnd_sum[rds_pkg::SUM_W-1:rds_pkg::COEF_W];
				end else begin
					// decay truncates toward zero
					res_sign_q <= neg_q;
					res_mag_q  <= {{(rds_pkg::RMAG_W-(rds_pkg::ACC_W-rds_pkg::COEF_W)){1'b0}},
						acc_q[rds_pkg::ACC_W-1:rds_pkg::COEF_W]};
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) correction_q <= result;
	end

	assign out_valid  = out_valid_q;
	assign correction = correction_q;

`ifndef SYNTHESIS
	// a new result appears only from the output step
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rds_pkg::S_OUT))
		else $error("result loaded outside output step");

	// an input transfer starts the preparation step
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == rds_pkg::S_PREP)
		else $error("input transfer did not start a frame");

	// digit counter is back at zero whenever the block is idle
	a_digit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rds_pkg::S_IDLE |-> dig_q == '0)
		else $error("digit counter left nonzero");

	// the smoothing state never reaches the most negative code
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q != $signed({1'b1, {(rds_pkg::DATA_W-1){1'b0}}}))
		else $error("smoothing state out of range");
`endif

endmodule
`default_nettype wire

// File: bench/retune_delta_smoother_unit_tb.sv
// Self-checking testbench for the retune delta smoother: directed and random frames.
`timescale 1ns / 1ps
module retune_delta_smoother_unit_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RX_HOLD     = 300;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 50;
	// Indexes past the register file; writes there must be dropped
	localparam logic [rds_pkg::IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
	localparam logic [rds_pkg::IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

	// Predicts the correction per frame and checks results in order
	class correction_tracker;
		longint target, alpha, gain, vib, lim;
		longint delta;
		logic signed [rds_pkg::DATA_W-1:0] pending_corr[$];
		int errors;

		function new();
			target = longint'(rds_pkg::TARGET_RST);
			alpha  = longint'(rds_pkg::ALPHA_RST);
			gain   = longint'(rds_pkg::GAIN_RST);
			vib    = longint'(rds_pkg::VIB_RST);
			lim    = longint'(rds_pkg::LIMIT_RST);
			delta  = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [rds_pkg::IDX_W-1:0] idx, logic [rds_pkg::DATA_W-1:0] d);
			case (idx)
				rds_pkg::REG_TARGET: target = longint'(d[rds_pkg::PITCH_W-1:0]);
				rds_pkg::REG_ALPHA:  alpha  = longint'(d);
				rds_pkg::REG_GAIN:   gain   = longint'(d);
				rds_pkg::REG_VIB:    vib    = longint'(d[rds_pkg::PITCH_W-1:0]);
				rds_pkg::REG_LIMIT:  lim    = longint'(d[rds_pkg::PITCH_W-1:0]);
				default: ;
			endcase
		endfunction

		// divide by 2^sh, nearest, ties away from zero
		function longint div_round(longint v, int sh);
			longint m;
			m = ((v < 0 ? -v : v) + (longint'(1) << (sh - 1))) >>> sh;
			return v < 0 ? -m : m;
		endfunction

		// divide by 2^sh toward zero
		function longint div_trunc(longint v, int sh);
			longint m;
			m = (v < 0 ? -v : v) >>> sh;
			return v < 0 ? -m : m;
		endfunction

		function void note_frame(logic v, logic [rds_pkg::PITCH_W-1:0] p);
			longint raw, scaled, nxt;
			if (v) begin
				raw = target - longint'(p);
				if ((raw < 0 ? -raw : raw) < vib)
					scaled = 0;
				else
					scaled = div_round(raw * gain, 15);
				nxt = div_round(alpha * delta + (65536 - alpha) * scaled, 16);
				if (nxt > lim)
					nxt = lim;
				if (nxt < -lim)
					nxt = -lim;
			end else begin
				// decay only, no clamp
				nxt = div_trunc(alpha * delta, 16);
			end
			delta = nxt;
			pending_corr = {pending_corr, nxt[rds_pkg::DATA_W-1:0]};
		endfunction

		function void check_result(logic signed [rds_pkg::DATA_W-1:0] got);
			logic signed [rds_pkg::DATA_W-1:0] want;
			if (pending_corr.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected correction, expected none, actual %0d", $time, got);
				return;
			end
			want = pending_corr.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t ns: correction mismatch, expected %0d, actual %0d",
					$time, want, got);
			end
		endfunction

		function int pending();
			return pending_corr.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic voiced;
	logic [rds_pkg::PITCH_W-1:0] pitch_midi;
	logic out_valid;
	logic out_ready;
	logic signed [rds_pkg::DATA_W-1:0] correction;
	logic cfg_we;
	logic [rds_pkg::IDX_W-1:0] cfg_index;
	logic [rds_pkg::DATA_W-1:0] cfg_data;

	correction_tracker tracker = new();
	bit idle_en;
	bit rx_hold_req;
	int cycles;

	retune_delta_smoother_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.voiced(voiced),
		.pitch_midi(pitch_midi),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.correction(correction),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Input transfers feed the predictor, output transfers get checked
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			tracker.note_frame(voiced, pitch_midi);
		if (arst_n && out_valid && out_ready)
			tracker.check_result(correction);
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 19);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one frame, return at the edge of its transfer (valid left high)
	task automatic send_frame(logic v, logic [rds_pkg::PITCH_W-1:0] p);
		int n;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid   <= 1'b1;
		voiced     <= v;
		pitch_midi <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// One register write; caller lowers cfg_we after the last one
	task automatic write_reg(logic [rds_pkg::IDX_W-1:0] idx, logic [rds_pkg::DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		tracker.set_reg(idx, d);
	endtask

	task automatic apply_setting(logic [rds_pkg::DATA_W-1:0] tp,
			logic [rds_pkg::DATA_W-1:0] a, logic [rds_pkg::DATA_W-1:0] g,
			logic [rds_pkg::DATA_W-1:0] vb, logic [rds_pkg::DATA_W-1:0] lm);
		write_reg(rds_pkg::REG_TARGET, tp);
		write_reg(rds_pkg::REG_ALPHA, a);
		write_reg(rds_pkg::REG_GAIN, g);
		write_reg(rds_pkg::REG_VIB, vb);
		write_reg(rds_pkg::REG_LIMIT, lm);
		cfg_we <= 1'b0;
	endtask

	// Random register set, weighted toward realistic smoothing
	task automatic random_setting();
		logic [rds_pkg::DATA_W-1:0] tp, a, g, vb, lm;
		tp = 16'($urandom);
		case ($urandom_range(0, 3))
			0: a = 16'($urandom);
			3: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: a = 16'($urandom_range(50000, 65535));
		endcase
		case ($urandom_range(0, 3))
			0: g = 16'($urandom);
			3: g = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: g = 16'($urandom_range(24000, 40000));
		endcase
		vb = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 256));
		case ($urandom_range(0, 5))
			0: lm = 16'($urandom);
			1: lm = 16'h0000;
			default: lm = 16'($urandom_range(256, 8192));
		endcase
		// upper bit of the 15-bit registers is don't-care
		if ($urandom_range(0, 1)) begin
			vb[rds_pkg::DATA_W-1] = 1'b1;
			lm[rds_pkg::DATA_W-1] = 1'b1;
		end
		apply_setting(tp, a, g, vb, lm);
	endtask

	// Pitch mostly near the target so the vibrato band and clamp both matter
	function automatic logic [rds_pkg::PITCH_W-1:0] random_pitch();
		int p;
		if ($urandom_range(0, 4) == 0)
			return rds_pkg::PITCH_W'($urandom);
		p = int'(tracker.target) + int'($urandom_range(0, 4095)) - 2048;
		if (p < 0)
			p = 0;
		if (p > 32767)
			p = 32767;
		return rds_pkg::PITCH_W'(p);
	endfunction

	initial begin
		int ph, k;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		voiced      = 1'b0;
		pitch_midi  = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_en     = 1'b1;
		rx_hold_req = 1'b0;
		cycles      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: on target, far below, far above, then decay
		send_frame(1'b1, 15'd15360);
		send_frame(1'b1, 15'd0);
		send_frame(1'b1, 15'h7FFF);
		send_frame(1'b0, 15'h7FFF);
		send_frame(1'b0, 15'd0);
		drain();

		// No smoothing, gain above unity, no bypass, widest limit
		apply_setting(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF);
		send_frame(1'b1, 15'd0);
		send_frame(1'b1, 15'h7FFF);
		send_frame(1'b0, 15'h5555);
		drain();

		// Maximal alpha, zero gain, widest vibrato band, zero limit
		apply_setting(16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000);
		send_frame(1'b1, 15'd0);
		send_frame(1'b1, 15'h7FFF);
		drain();

		// Writes past the register file change nothing
		write_reg(IDX_UNUSED_LO, 16'hFFFF);
		write_reg(IDX_UNUSED_HI, 16'h1234);
		cfg_we <= 1'b0;
		send_frame(1'b1, 15'h2AAA);
		drain();

		// Limit lowered while unvoiced: decay is not clamped, next voiced frame is
		apply_setting(16'd20000, 16'h0000, 16'd32768, 16'h0000, 16'h7FFF);
		send_frame(1'b1, 15'd0);
		drain();
		write_reg(rds_pkg::REG_ALPHA, 16'd32768);
		write_reg(rds_pkg::REG_LIMIT, 16'd100);
		cfg_we <= 1'b0;
		send_frame(1'b0, 15'd1234);
		send_frame(1'b1, 15'd20000);
		drain();

		// Random phases, each under its own register setting
		for (ph = 0; ph < PHASES; ph++) begin
			idle_en = (ph >= PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			random_setting();
			// long receiver hold-off so the block backs up into its input
			if (ph == 2)
				rx_hold_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				send_frame($urandom_range(0, 4) != 0, random_pitch());
				// sender pauses until everything is back
				if (ph == 4 && k == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (tracker.pending() != 0);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
